/* rtl/core/c2d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg
// shared constants, types and helpers of the fixed point conv2d relu block
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int MAX_IN_CHANNELS  = 32;
  localparam int MAX_OUT_CHANNELS = 32;
  localparam int MAX_KERNEL       = 9;
  localparam int MAX_HEIGHT       = 64;
  localparam int MAX_WIDTH        = 64;
  localparam int FRACT_BITS       = 26;

  localparam int SAMPLE_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int BIAS_DEPTH   = MAX_OUT_CHANNELS;

  localparam int SAMPLE_AW = $clog2(SAMPLE_DEPTH);
  localparam int WEIGHT_AW = $clog2(WEIGHT_DEPTH);
  localparam int BIAS_AW   = $clog2(BIAS_DEPTH);

  localparam int DATA_W = 32;

  // operation codes carried on tuser
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_WEIGHT  = 2'd1;
  localparam logic [1:0] OP_BIAS    = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
  localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
  localparam logic [2:0] REG_KERNEL_SIZE  = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;

  typedef struct packed {
    logic [5:0] in_channels;
    logic [5:0] out_channels;
    logic [3:0] kernel_size;
    logic [6:0] image_height;
    logic [6:0] image_width;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic setup1;
    logic setup2;
    logic setup3;
    logic issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } status_t;

  // clamp a register write into 1..hi
  function automatic logic [6:0] sat_reg(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/c2d_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/c2d_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ctrl
// sequencer for request intake, setup, tap loop, drain and result handoff
// ----------------------------------------------------------------------------
module c2d_ctrl
  import c2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  output cmd_t       cmd,
  input  status_t    status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP1 = 3'd1;
  localparam logic [2:0] ST_SETUP2 = 3'd2;
  localparam logic [2:0] ST_SETUP3 = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready     = (state == ST_IDLE);
  assign cmd.accept   = in_valid && (state == ST_IDLE);
  assign cmd.setup1   = (state == ST_SETUP1);
  assign cmd.setup2   = (state == ST_SETUP2);
  assign cmd.setup3   = (state == ST_SETUP3);
  assign cmd.issue    = (state == ST_RUN);
  assign cmd.out_load = (state == ST_FINISH) && status.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && in_op == OP_COMPUTE && status.in_range) begin
          state_next = ST_SETUP1;
        end
      end
      ST_SETUP1: state_next = ST_SETUP2;
      ST_SETUP2: state_next = ST_SETUP3;
      ST_SETUP3: state_next = ST_RUN;
      ST_RUN: begin
        if (status.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/c2d_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_dp
// stores, tap address generation, mac pipeline, bias, relu and output register
// ----------------------------------------------------------------------------
module c2d_dp
  import c2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [1:0]  in_op,
  input  logic [16:0] in_index,
  input  logic [31:0] in_value,
  input  logic [4:0]  in_channel,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_value,
  output logic [4:0]  out_channel,
  output logic [5:0]  out_row,
  output logic [5:0]  out_col
);

  // latched request
  logic [4:0] req_k;
  logic [5:0] req_row;
  logic [5:0] req_col;

  // setup products
  logic [7:0]  kk;
  logic [12:0] hw;
  logic [3:0]  half;
  logic [11:0] ckk;

  // tap counters
  logic [3:0]  tap_m;
  logic [3:0]  tap_l;
  logic [4:0]  tap_n;
  logic [16:0] pbase;
  logic [16:0] waddr;

  // stage 1
  logic        v1;
  logic [11:0] yw1;
  logic [5:0]  xcl1;
  logic [16:0] pbase1;
  logic [16:0] waddr1;
  // stage 2 (ram read) and stage 3 (product)
  logic               v2;
  logic               v3;
  logic signed [63:0] prod;
  logic [31:0]        acc;

  logic [31:0] s_rdata;
  logic [31:0] w_rdata;
  logic [31:0] b_rdata;

  logic signed [8:0] ysum;
  logic signed [8:0] xsum;
  logic [5:0]        ycl;
  logic [5:0]        xcl;
  logic [13:0]       ckk_full;
  logic [13:0]       hw_full;
  logic [16:0]       saddr;
  logic [31:0]       biased;
  logic              m_last;
  logic              l_last;
  logic              n_last;
  logic              load_cycle;

  assign load_cycle = cmd.accept;

  c2d_ram #(.WIDTH(DATA_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (load_cycle && in_op == OP_SAMPLE),
    .waddr (in_index[SAMPLE_AW-1:0]),
    .wdata (in_value),
    .raddr (saddr[SAMPLE_AW-1:0]),
    .rdata (s_rdata)
  );

  c2d_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (load_cycle && in_op == OP_WEIGHT && {15'd0, in_index} < WEIGHT_DEPTH),
    .waddr (in_index[WEIGHT_AW-1:0]),
    .wdata (in_value),
    .raddr (waddr1[WEIGHT_AW-1:0]),
    .rdata (w_rdata)
  );

  c2d_ram #(.WIDTH(DATA_W), .DEPTH(BIAS_DEPTH)) u_bias_ram (
    .clk   (clk),
    .we    (load_cycle && in_op == OP_BIAS && {15'd0, in_index} < BIAS_DEPTH),
    .waddr (in_index[BIAS_AW-1:0]),
    .wdata (in_value),
    .raddr (req_k[BIAS_AW-1:0]),
    .rdata (b_rdata)
  );

  assign status.in_range = ({1'b0, in_channel} < cfg.out_channels) &&
                           ({1'b0, in_row} < cfg.image_height) &&
                           ({1'b0, in_col} < cfg.image_width);

  assign m_last = (tap_m == cfg.kernel_size - 4'd1);
  assign l_last = (tap_l == cfg.kernel_size - 4'd1);
  assign n_last = ({1'b0, tap_n} == cfg.in_channels - 6'd1);
  assign status.last_tap  = m_last && l_last && n_last;
  assign status.pipe_busy = v1 || v2 || v3;
  assign status.out_free  = !out_valid || out_ready;

  // replicate padding: clamp window coordinates into the image
  assign ysum = $signed({3'd0, req_row}) + $signed({5'd0, tap_l}) - $signed({5'd0, half});
  assign xsum = $signed({3'd0, req_col}) + $signed({5'd0, tap_m}) - $signed({5'd0, half});

  always_comb begin
    if (ysum < 0) begin
      ycl = 6'd0;
    end else if (ysum >= $signed({2'd0, cfg.image_height})) begin
      ycl = 6'(cfg.image_height - 7'd1);
    end else begin
      ycl = ysum[5:0];
    end
    if (xsum < 0) begin
      xcl = 6'd0;
    end else if (xsum >= $signed({2'd0, cfg.image_width})) begin
      xcl = 6'(cfg.image_width - 7'd1);
    end else begin
      xcl = xsum[5:0];
    end
  end

  assign hw_full  = {7'd0, cfg.image_height} * {7'd0, cfg.image_width};
  assign ckk_full = {8'd0, cfg.in_channels} * {6'd0, kk};
  assign saddr    = pbase1 + {5'd0, yw1} + {11'd0, xcl1};
  assign biased   = acc + b_rdata;

  // request latch and setup
  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_COMPUTE) begin
      req_k   <= in_channel;
      req_row <= in_row;
      req_col <= in_col;
    end
    if (cmd.setup1) begin
      kk   <= {4'd0, cfg.kernel_size} * {4'd0, cfg.kernel_size};
      hw   <= hw_full[12:0];
      half <= cfg.kernel_size >> 1;
    end
    if (cmd.setup2) begin
      ckk <= ckk_full[11:0];
    end
  end

  // tap counters, innermost column then row then input channel
  always_ff @(posedge clk) begin
    if (cmd.setup3) begin
      tap_m <= 4'd0;
      tap_l <= 4'd0;
      tap_n <= 5'd0;
      pbase <= 17'd0;
      waddr <= {12'd0, req_k} * {5'd0, ckk};
    end else if (cmd.issue) begin
      waddr <= waddr + 17'd1;
      if (m_last) begin
        tap_m <= 4'd0;
        if (l_last) begin
          tap_l <= 4'd0;
          tap_n <= tap_n + 5'd1;
          pbase <= pbase + {4'd0, hw};
        end else begin
          tap_l <= tap_l + 4'd1;
        end
      end else begin
        tap_m <= tap_m + 4'd1;
      end
    end
  end

  // mac pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    yw1    <= 12'(ycl * cfg.image_width);
    xcl1   <= xcl;
    pbase1 <= pbase;
    waddr1 <= waddr;
    prod   <= $signed(s_rdata) * $signed(w_rdata);
    if (cmd.setup3) begin
      acc <= 32'd0;
    end else if (v3) begin
      acc <= acc + prod[FRACT_BITS +: DATA_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value   <= biased[31] ? 31'd0 : biased[30:0];
      out_channel <= req_k;
      out_row     <= req_row;
      out_col     <= req_col;
    end
  end

endmodule

/* rtl/core/conv2d_fixed_point_relu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_fixed_point_relu
// multi-channel q5.26 2d convolution element with bias, relu and edge clamp
// ----------------------------------------------------------------------------
// load beats (sample, weight, bias) are taken back to back, one per cycle while idle
// a compute beat steps through setup, the tap loop, a pipeline drain and the
// result handoff before the next beat is taken, one multiply-accumulate per
// cycle through the sample and weight ram read ports
// the result is loaded into the output register once the output is free;
// rst clears control state and config, stores are not cleared
// ----------------------------------------------------------------------------
module conv2d_fixed_point_relu
  import c2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // store_index[16:0], load_value[48:17], out_channel[53:49],
                                // out_row[59:54], out_col[65:60], zero[71:66]
  input  logic [1:0]  s_tuser,  // operation[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // result_value[30:0], result_channel[35:31],
                                // result_row[41:36], result_col[47:42]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  logic       cfg_we;
  logic [2:0] cfg_idx;

  logic [30:0] res_value;
  logic [4:0]  res_channel;
  logic [5:0]  res_row;
  logic [5:0]  res_col;

  // apb register file, always ready, writes saturate into range
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_channels  <= 6'd1;
      cfg.out_channels <= 6'd1;
      cfg.kernel_size  <= 4'd3;
      cfg.image_height <= 7'd64;
      cfg.image_width  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IN_CHANNELS:
          cfg.in_channels  <= 6'(sat_reg({1'b0, pwdata[5:0]}, 7'(MAX_IN_CHANNELS)));
        REG_OUT_CHANNELS:
          cfg.out_channels <= 6'(sat_reg({1'b0, pwdata[5:0]}, 7'(MAX_OUT_CHANNELS)));
        REG_KERNEL_SIZE:
          cfg.kernel_size  <= 4'(sat_reg({3'd0, pwdata[3:0]}, 7'(MAX_KERNEL)));
        REG_IMAGE_HEIGHT:
          cfg.image_height <= sat_reg(pwdata[6:0], 7'(MAX_HEIGHT));
        REG_IMAGE_WIDTH:
          cfg.image_width  <= sat_reg(pwdata[6:0], 7'(MAX_WIDTH));
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IN_CHANNELS:  prdata = {26'd0, cfg.in_channels};
      REG_OUT_CHANNELS: prdata = {26'd0, cfg.out_channels};
      REG_KERNEL_SIZE:  prdata = {28'd0, cfg.kernel_size};
      REG_IMAGE_HEIGHT: prdata = {25'd0, cfg.image_height};
      REG_IMAGE_WIDTH:  prdata = {25'd0, cfg.image_width};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer: takes beats only while idle, steps the datapath through
  // setup, one tap per cycle, pipeline drain and result handoff
  c2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath: stores, address counters, mac pipeline and output register
  c2d_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .in_op       (s_tuser),
    .in_index    (s_tdata[16:0]),
    .in_value    (s_tdata[48:17]),
    .in_channel  (s_tdata[53:49]),
    .in_row      (s_tdata[59:54]),
    .in_col      (s_tdata[65:60]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_value   (res_value),
    .out_channel (res_channel),
    .out_row     (res_row),
    .out_col     (res_col)
  );

  assign m_tdata = {res_col, res_row, res_channel, res_value};

  // no new beat while taps are still in the mac pipeline
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !status.pipe_busy)
    else $error("input taken while mac pipeline busy");

  // a result only appears after the sequencer loaded the output register
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result valid without load");

  // in_channels and kernel_size stay in their saturated ranges, image sizes nonzero
  assert property (@(posedge clk) disable iff (rst)
    cfg.in_channels != 6'd0 && cfg.in_channels <= 6'(MAX_IN_CHANNELS) &&
    cfg.kernel_size != 4'd0 && cfg.kernel_size <= 4'(MAX_KERNEL) &&
    cfg.image_height != 7'd0 && cfg.image_width != 7'd0)
    else $error("config register out of range");

  // the output register is never reloaded while a result waits
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

endmodule
